// ----- design/dppm_pkg.sv -----
// shared types and constants of the disc pulse power meter
package dppm_pkg;

  localparam int unsigned TimeBitsDef = 32;
  localparam int unsigned QuoBits     = 32;
  localparam int unsigned CntBits     = $clog2(QuoBits);
  localparam int unsigned PowerBits   = 24;

  localparam logic [15:0] MinOffRst  = 16'd100;
  localparam logic [31:0] EnergyRst  = 32'd24000000;
  localparam logic [PowerBits-1:0] PowerMax = {PowerBits{1'b1}};

  // register indexes of the write port
  localparam logic CfgMinOff = 1'b0;
  localparam logic CfgEnergy = 1'b1;

  // sensor level codes as kept in the tracker
  localparam logic [1:0] LvlLow     = 2'd0;
  localparam logic [1:0] LvlHigh    = 2'd1;
  localparam logic [1:0] LvlUnknown = 2'd2;

  typedef struct packed {
    logic        level;
    logic [31:0] time_ms;
  } in_t;

  typedef struct packed {
    logic [31:0]          period_ms;
    logic [PowerBits-1:0] power_w;
    logic [31:0]          off_len_ms;
    logic [31:0]          on_len_ms;
  } out_t;

endpackage

// ----- design/dppm_track.sv -----
// phase timing and disc mark detection
module dppm_track #(
  parameter int unsigned TimeBits = dppm_pkg::TimeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                level_i,
  input  logic [TimeBits-1:0] now_i,
  input  logic [15:0]         min_off_i,
  output logic                fire_o,
  output logic [TimeBits-1:0] period_o,
  output logic [TimeBits-1:0] off_len_o,
  output logic [TimeBits-1:0] on_len_o
);
  import dppm_pkg::*;

  logic [1:0]          prev_q, prev_d;
  logic                seen_q, seen_d;
  logic [TimeBits-1:0] mark_q, mark_d;
  logic [TimeBits-1:0] on_start_q, on_start_d, on_len_q, on_len_d;
  logic [TimeBits-1:0] off_start_q, off_start_d, off_len_q, off_len_d;
  logic                on_trk_q, on_trk_d, off_trk_q, off_trk_d;
  logic [TimeBits+15:0] min_ext;
  logic                qual, mark_edge;

  assign min_ext   = {{TimeBits{1'b0}}, min_off_i};
  assign qual      = off_len_q > min_ext[TimeBits-1:0];
  assign mark_edge = qual && !level_i && (prev_q == LvlHigh);

  assign fire_o    = accept_i && mark_edge && seen_q;
  assign period_o  = now_i - mark_q;
  assign off_len_o = off_len_q;
  assign on_len_o  = on_len_q;

  always_comb begin
    prev_d      = prev_q;
    seen_d      = seen_q;
    mark_d      = mark_q;
    on_start_d  = on_start_q;
    on_len_d    = on_len_q;
    on_trk_d    = on_trk_q;
    off_start_d = off_start_q;
    off_len_d   = off_len_q;
    off_trk_d   = off_trk_q;
    if (mark_edge) begin
      prev_d = LvlLow;
      mark_d = now_i;
      seen_d = 1'b1;
    end else if (qual && level_i) begin
      prev_d = LvlHigh;
    end
    if (!level_i) begin
      if (!on_trk_q) begin
        on_start_d = now_i;
        on_trk_d   = 1'b1;
        off_trk_d  = 1'b0;
        on_len_d   = '0;
      end else begin
        on_len_d = now_i - on_start_q;
      end
    end else begin
      if (!off_trk_q) begin
        off_start_d = now_i;
        off_trk_d   = 1'b1;
        on_trk_d    = 1'b0;
        off_len_d   = '0;
      end else begin
        off_len_d = now_i - off_start_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= LvlUnknown;
      seen_q      <= 1'b0;
      mark_q      <= '0;
      on_start_q  <= '0;
      on_len_q    <= '0;
      on_trk_q    <= 1'b0;
      off_start_q <= '0;
      off_len_q   <= '0;
      off_trk_q   <= 1'b0;
    end else if (accept_i) begin
      prev_q      <= prev_d;
      seen_q      <= seen_d;
      mark_q      <= mark_d;
      on_start_q  <= on_start_d;
      on_len_q    <= on_len_d;
      on_trk_q    <= on_trk_d;
      off_start_q <= off_start_d;
      off_len_q   <= off_len_d;
      off_trk_q   <= off_trk_d;
    end
  end

endmodule

// ----- design/dppm_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
module dppm_div #(
  parameter int unsigned TimeBits = dppm_pkg::TimeBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [dppm_pkg::QuoBits-1:0] dividend_i,
  input  logic [TimeBits-1:0]          divisor_i,
  output logic                         idle_o,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output logic [dppm_pkg::QuoBits-1:0] quotient_o
);
  import dppm_pkg::*;

  typedef enum logic [1:0] {
    DivIdle,
    DivRun,
    DivDone
  } div_state_e;

  div_state_e          state_q;
  logic [CntBits-1:0]  cnt_q;
  logic [TimeBits-1:0] rem_q, dvs_q;
  logic [QuoBits-1:0]  quo_q;
  logic [TimeBits:0]   trial, diff;
  logic                qbit;

  // shift the next dividend bit into the partial remainder and try a subtract
  assign trial = {rem_q, quo_q[QuoBits-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign qbit  = !diff[TimeBits];

  assign idle_o      = (state_q == DivIdle);
  assign res_valid_o = (state_q == DivDone);
  assign quotient_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DivIdle;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        DivIdle: begin
          if (start_i) begin
            state_q <= DivRun;
            cnt_q   <= CntBits'(QuoBits - 1);
          end
        end
        DivRun: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= DivDone;
          end
        end
        DivDone: begin
          if (res_ready_i) begin
            state_q <= DivIdle;
          end
        end
        default: state_q <= DivIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == DivIdle && start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (state_q == DivRun) begin
      rem_q <= qbit ? diff[TimeBits-1:0] : trial[TimeBits-1:0];
      quo_q <= {quo_q[QuoBits-2:0], qbit};
    end
  end

endmodule

// ----- design/disc_pulse_power_meter_unit.sv -----
// top level of the disc pulse power meter
// latency: a sample that causes no result is done in the cycle it is taken; a sample that
// completes a revolution starts the divider; its result is registered as a beat
// throughput: one sample per cycle while the divider is idle; the 32-step serial
// divider holds off new samples after a mark until the output register takes its result
// reset: asynchronous, clears phase tracking, mark state and config to defaults
module disc_pulse_power_meter_unit #(
  parameter int unsigned TimeBits = dppm_pkg::TimeBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dppm_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dppm_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [31:0]    cfg_wdata_i
);
  import dppm_pkg::*;

  // configuration registers
  logic [15:0] min_off_q;
  logic [31:0] energy_q;

  // sample side
  logic                 in_acc;
  logic [TimeBits+31:0] time_ext;
  logic [TimeBits-1:0]  now;

  // tracker results
  logic                fire;
  logic [TimeBits-1:0] period, off_len, on_len;

  // divider handshake
  logic               div_idle, div_valid, div_ready;
  logic [QuoBits-1:0] quo;

  // fields held while the divide runs
  logic [31:0] pend_period_q, pend_off_q, pend_on_q;
  logic [TimeBits+31:0] period_ext, off_ext, on_ext;

  // output register
  out_t            out_q;
  logic            out_valid_q;
  logic [PowerBits-1:0] power;

  // a new sample is taken whenever the divider is free, even with a beat waiting
  assign in_ready_o = div_idle;
  assign in_acc     = in_valid_i && in_ready_o;

  // timestamps are kept modulo 2^TimeBits
  assign time_ext = {{TimeBits{1'b0}}, in_data_i.time_ms};
  assign now      = time_ext[TimeBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_off_q <= MinOffRst;
      energy_q  <= EnergyRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMinOff: min_off_q <= cfg_wdata_i[15:0];
        CfgEnergy: energy_q  <= cfg_wdata_i;
        default:   ;
      endcase
    end
  end

  dppm_track #(
    .TimeBits (TimeBits)
  ) u_track (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_acc),
    .level_i   (in_data_i.level),
    .now_i     (now),
    .min_off_i (min_off_q),
    .fire_o    (fire),
    .period_o  (period),
    .off_len_o (off_len),
    .on_len_o  (on_len)
  );

  // power = energy / period; a zero period yields all ones and saturates below
  dppm_div #(
    .TimeBits (TimeBits)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (fire),
    .dividend_i  (energy_q),
    .divisor_i   (period),
    .idle_o      (div_idle),
    .res_valid_o (div_valid),
    .res_ready_i (div_ready),
    .quotient_o  (quo)
  );

  // reported fields are the low 32 bits of the time differences
  assign period_ext = {32'd0, period};
  assign off_ext    = {32'd0, off_len};
  assign on_ext     = {32'd0, on_len};

  always_ff @(posedge clk_i) begin
    if (fire) begin
      pend_period_q <= period_ext[31:0];
      pend_off_q    <= off_ext[31:0];
      pend_on_q     <= on_ext[31:0];
    end
  end

  // saturate the quotient to the power field
  assign power = (quo[QuoBits-1:PowerBits] != '0) ? PowerMax : quo[PowerBits-1:0];

  // the divider hands over when the output register is empty or draining
  assign div_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (div_valid && div_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_valid && div_ready) begin
      out_q.period_ms  <= pend_period_q;
      out_q.power_w    <= power;
      out_q.off_len_ms <= pend_off_q;
      out_q.on_len_ms  <= pend_on_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
